/* sv/nifd_pkg.sv */
// ----------------------------------------------------------------------------
// NEC infrared frame decoder package
// Shared types, register indexes, reset values and the window compare.
// ----------------------------------------------------------------------------
`default_nettype none

package nifd_pkg;

   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH  = 16;
   localparam int unsigned BITS_PER_BYTE   = 8;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_BURST_WINDOW  = 3'd0,
      CSR_GAP_WINDOW    = 3'd1,
      CSR_HOLD_WINDOW   = 3'd2,
      CSR_MARK_WINDOW   = 3'd3,
      CSR_ZERO_WINDOW   = 3'd4,
      CSR_ONE_WINDOW    = 3'd5,
      CSR_HOLD_TIMEOUT  = 3'd6,
      CSR_EXTENDED_MODE = 3'd7
   } csr_index_type;

   localparam logic [15:0] BURST_WINDOW_RESET = 16'hA078;
   localparam logic [15:0] GAP_WINDOW_RESET   = 16'h503C;
   localparam logic [15:0] HOLD_WINDOW_RESET  = 16'h2A1C;
   localparam logic [15:0] MARK_WINDOW_RESET  = 16'h0D05;
   localparam logic [15:0] ZERO_WINDOW_RESET  = 16'h0D05;
   localparam logic [15:0] ONE_WINDOW_RESET   = 16'h2014;
   localparam logic [7:0]  HOLD_TIMEOUT_RESET = 8'd4;
   localparam logic        EXTENDED_RESET     = 1'b0;

   typedef enum logic [1:0] {
      OP_TICK = 2'd0,
      OP_EDGE = 2'd1,
      OP_ACK  = 2'd2,
      OP_NONE = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      PH_BURST    = 3'd0,
      PH_GAP      = 3'd1,
      PH_ADDR     = 3'd2,
      PH_ADDR_INV = 3'd3,
      PH_CMD      = 3'd4,
      PH_CMD_INV  = 3'd5
   } phase_type;

   typedef struct packed {
      logic [1:0] opcode;
      logic       level;
   } req_type;

   typedef struct packed {
      logic [7:0] address_low;
      logic [7:0] address_high;
      logic [7:0] command;
      logic       received;
      logic       signal_valid;
      logic       key_hold;
   } rsp_type;

   // Strict window test: the minimum sits in the low byte, the maximum in the high byte.
   function automatic logic in_window(input logic [15:0] window, input logic [7:0] ticks);
      in_window = (ticks > window[7:0]) && (ticks < window[15:8]);
   endfunction

endpackage

`default_nettype wire

/* sv/nec_ir_frame_decoder_unit.sv */
// ----------------------------------------------------------------------------
// NEC infrared frame decoder unit
// Decodes NEC frames from timer tick and pin edge events.
// ----------------------------------------------------------------------------
// Usage:
//   The request channel carries one event per transfer: a timer tick, a pin
//   edge with the new pin level, or an acknowledge of a received frame.
//   Every request transfer yields exactly one response transfer that shows
//   the latched address and command bytes and the received, signal-valid and
//   key-hold flags as they stand after the event.
//   The decoder state and the response output register are both loaded from
//   the request transfer, and one event is taken in every cycle while the
//   receiver does not stall.
//   When the receiver stalls, the response register holds its value and
//   req_stall rises, so at most one response waits at any time; the next
//   request is taken in the cycle the waiting response leaves.
//   Reset clears the decoder state and the flags, empties the response
//   register and restores every configuration register to its default.
//   Configuration writes through the csr_ port take effect at once and are
//   meant for idle periods only.
// ----------------------------------------------------------------------------
`default_nettype none

module nec_ir_frame_decoder_unit (
   input  wire  logic                                     clock,
   input  wire  logic                                     reset,
   input  wire  logic                                     req_valid,
   output       logic                                     req_stall,
   input  wire  nifd_pkg::req_type                        req_data,
   output       logic                                     rsp_valid,
   input  wire  logic                                     rsp_stall,
   output       nifd_pkg::rsp_type                        rsp_data,
   input  wire  logic                                     csr_we,
   input  wire  logic [nifd_pkg::CSR_INDEX_WIDTH-1:0]     csr_index,
   input  wire  logic [nifd_pkg::CSR_DATA_WIDTH-1:0]      csr_wdata
);

   logic [15:0] burst_window_ff;
   logic [15:0] gap_window_ff;
   logic [15:0] hold_window_ff;
   logic [15:0] mark_window_ff;
   logic [15:0] zero_window_ff;
   logic [15:0] one_window_ff;
   logic [7:0]  hold_timeout_ff;
   logic        extended_ff;

   nifd_pkg::phase_type phase_ff, phase_in;
   logic [2:0]  bit_count_ff, bit_count_in;
   logic [7:0]  tick_count_ff, tick_count_in;
   logic        overflow_ff, overflow_in;
   logic [7:0]  countdown_ff, countdown_in;
   logic [7:0]  shift_low_ff, shift_low_in;
   logic [7:0]  shift_high_ff, shift_high_in;
   logic [7:0]  shift_cmd_ff, shift_cmd_in;
   logic [7:0]  held_low_ff, held_low_in;
   logic [7:0]  held_high_ff, held_high_in;
   logic [7:0]  held_cmd_ff, held_cmd_in;
   logic        received_ff, received_in;
   logic        valid_flag_ff, valid_flag_in;
   logic        hold_flag_ff, hold_flag_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   nifd_pkg::rsp_type    rsp_data_ff, rsp_data_in;

   logic accept;
   logic is_zero;
   logic is_one;
   logic bit_value;
   logic bit_ok;
   logic byte_done;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign is_zero   = nifd_pkg::in_window(zero_window_ff, tick_count_ff);
   assign is_one    = nifd_pkg::in_window(one_window_ff, tick_count_ff);
   assign bit_value = !is_zero;
   assign byte_done = (bit_count_ff == 3'(nifd_pkg::BITS_PER_BYTE - 1));

   // A space that fits a bit window is rejected only by a failed inverse check.
   always_comb begin
      bit_ok = is_zero || is_one;
      case (phase_ff)
         nifd_pkg::PH_ADDR_INV: begin
            if (!extended_ff && (shift_low_ff[bit_count_ff] == bit_value)) begin
               bit_ok = 1'b0;
            end
         end
         nifd_pkg::PH_CMD_INV: begin
            if (shift_cmd_ff[bit_count_ff] == bit_value) begin
               bit_ok = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      phase_in      = phase_ff;
      bit_count_in  = bit_count_ff;
      tick_count_in = tick_count_ff;
      overflow_in   = overflow_ff;
      countdown_in  = countdown_ff;
      shift_low_in  = shift_low_ff;
      shift_high_in = shift_high_ff;
      shift_cmd_in  = shift_cmd_ff;
      held_low_in   = held_low_ff;
      held_high_in  = held_high_ff;
      held_cmd_in   = held_cmd_ff;
      received_in   = received_ff;
      valid_flag_in = valid_flag_ff;
      hold_flag_in  = hold_flag_ff;
      if (accept) begin
         case (req_data.opcode)
            nifd_pkg::OP_TICK: begin
               tick_count_in = tick_count_ff + 8'd1;
               if (tick_count_ff == 8'hFF) begin
                  overflow_in = 1'b1;
                  if (countdown_ff != 8'd0) begin
                     countdown_in = countdown_ff - 8'd1;
                     if (countdown_ff == 8'd1) begin
                        valid_flag_in = 1'b0;
                        hold_flag_in  = 1'b0;
                     end
                  end
               end
            end
            nifd_pkg::OP_EDGE: begin
               if (overflow_ff) begin
                  overflow_in   = 1'b0;
                  phase_in      = nifd_pkg::PH_BURST;
                  tick_count_in = 8'd0;
               end else begin
                  case (phase_ff)
                     nifd_pkg::PH_BURST: begin
                        if (!req_data.level) begin
                           tick_count_in = 8'd0;
                        end else if (nifd_pkg::in_window(burst_window_ff, tick_count_ff)) begin
                           phase_in      = nifd_pkg::PH_GAP;
                           tick_count_in = 8'd0;
                        end
                     end
                     nifd_pkg::PH_GAP: begin
                        phase_in = nifd_pkg::PH_BURST;
                        if (!req_data.level) begin
                           if (nifd_pkg::in_window(gap_window_ff, tick_count_ff)) begin
                              tick_count_in = 8'd0;
                              phase_in      = nifd_pkg::PH_ADDR;
                              bit_count_in  = 3'd0;
                              hold_flag_in  = 1'b0;
                           end else if (nifd_pkg::in_window(hold_window_ff, tick_count_ff)
                                        && valid_flag_ff) begin
                              hold_flag_in = 1'b1;
                              countdown_in = hold_timeout_ff;
                           end
                        end
                     end
                     nifd_pkg::PH_ADDR, nifd_pkg::PH_ADDR_INV,
                     nifd_pkg::PH_CMD, nifd_pkg::PH_CMD_INV: begin
                        if (req_data.level) begin
                           if (nifd_pkg::in_window(mark_window_ff, tick_count_ff)) begin
                              tick_count_in = 8'd0;
                           end else begin
                              phase_in = nifd_pkg::PH_BURST;
                           end
                        end else if (!bit_ok) begin
                           phase_in = nifd_pkg::PH_BURST;
                        end else begin
                           if (phase_ff == nifd_pkg::PH_ADDR) begin
                              shift_low_in[bit_count_ff] = bit_value;
                           end
                           if (phase_ff == nifd_pkg::PH_ADDR_INV && extended_ff) begin
                              shift_high_in[bit_count_ff] = bit_value;
                           end
                           if (phase_ff == nifd_pkg::PH_CMD) begin
                              shift_cmd_in[bit_count_ff] = bit_value;
                           end
                           tick_count_in = 8'd0;
                           bit_count_in  = bit_count_ff + 3'd1;
                           if (byte_done) begin
                              if (phase_ff == nifd_pkg::PH_CMD_INV) begin
                                 phase_in = nifd_pkg::PH_BURST;
                                 if (!received_ff) begin
                                    held_low_in   = shift_low_ff;
                                    held_high_in  = extended_ff ? shift_high_ff : 8'd0;
                                    held_cmd_in   = shift_cmd_ff;
                                    received_in   = 1'b1;
                                    valid_flag_in = 1'b1;
                                    countdown_in  = hold_timeout_ff;
                                 end
                              end else begin
                                 phase_in = nifd_pkg::phase_type'(phase_ff + 3'd1);
                              end
                           end
                        end
                     end
                     default: begin
                        phase_in = nifd_pkg::PH_BURST;
                     end
                  endcase
               end
            end
            nifd_pkg::OP_ACK: begin
               received_in = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      rsp_data_in.address_low  = held_low_in;
      rsp_data_in.address_high = held_high_in;
      rsp_data_in.command      = held_cmd_in;
      rsp_data_in.received     = received_in;
      rsp_data_in.signal_valid = valid_flag_in;
      rsp_data_in.key_hold     = hold_flag_in;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         burst_window_ff <= nifd_pkg::BURST_WINDOW_RESET;
         gap_window_ff   <= nifd_pkg::GAP_WINDOW_RESET;
         hold_window_ff  <= nifd_pkg::HOLD_WINDOW_RESET;
         mark_window_ff  <= nifd_pkg::MARK_WINDOW_RESET;
         zero_window_ff  <= nifd_pkg::ZERO_WINDOW_RESET;
         one_window_ff   <= nifd_pkg::ONE_WINDOW_RESET;
         hold_timeout_ff <= nifd_pkg::HOLD_TIMEOUT_RESET;
         extended_ff     <= nifd_pkg::EXTENDED_RESET;
      end else if (csr_we) begin
         case (nifd_pkg::csr_index_type'(csr_index))
            nifd_pkg::CSR_BURST_WINDOW:  burst_window_ff <= csr_wdata;
            nifd_pkg::CSR_GAP_WINDOW:    gap_window_ff   <= csr_wdata;
            nifd_pkg::CSR_HOLD_WINDOW:   hold_window_ff  <= csr_wdata;
            nifd_pkg::CSR_MARK_WINDOW:   mark_window_ff  <= csr_wdata;
            nifd_pkg::CSR_ZERO_WINDOW:   zero_window_ff  <= csr_wdata;
            nifd_pkg::CSR_ONE_WINDOW:    one_window_ff   <= csr_wdata;
            nifd_pkg::CSR_HOLD_TIMEOUT:  hold_timeout_ff <= csr_wdata[7:0];
            nifd_pkg::CSR_EXTENDED_MODE: extended_ff     <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= nifd_pkg::PH_BURST;
         bit_count_ff  <= 3'd0;
         tick_count_ff <= 8'd0;
         overflow_ff   <= 1'b0;
         countdown_ff  <= 8'd0;
         shift_low_ff  <= 8'd0;
         shift_high_ff <= 8'd0;
         shift_cmd_ff  <= 8'd0;
         held_low_ff   <= 8'd0;
         held_high_ff  <= 8'd0;
         held_cmd_ff   <= 8'd0;
         received_ff   <= 1'b0;
         valid_flag_ff <= 1'b0;
         hold_flag_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         bit_count_ff  <= bit_count_in;
         tick_count_ff <= tick_count_in;
         overflow_ff   <= overflow_in;
         countdown_ff  <= countdown_in;
         shift_low_ff  <= shift_low_in;
         shift_high_ff <= shift_high_in;
         shift_cmd_ff  <= shift_cmd_in;
         held_low_ff   <= held_low_in;
         held_high_ff  <= held_high_in;
         held_cmd_ff   <= held_cmd_in;
         received_ff   <= received_in;
         valid_flag_ff <= valid_flag_in;
         hold_flag_ff  <= hold_flag_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

`default_nettype wire

/* sv/nifd_checker.sv */
// ----------------------------------------------------------------------------
// NEC infrared frame decoder checker
// Port-level assertions on the decoder unit, attached by a bind statement.
// ----------------------------------------------------------------------------
`default_nettype none

module nifd_checker (
   input wire logic                                  clock,
   input wire logic                                  reset,
   input wire logic                                  req_valid,
   input wire logic                                  req_stall,
   input wire logic                                  rsp_valid,
   input wire logic                                  rsp_stall,
   input wire nifd_pkg::rsp_type                     rsp_data
);

   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("Response valid after reset.");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("Request stalled while the response register could take a transfer.");

   a_transfer_gives_response: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> rsp_valid)
      else $error("Request transfer without a response.");

   a_hold_needs_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_data.key_hold || rsp_data.signal_valid))
      else $error("Key hold reported without a valid signal.");

   a_stalled_response_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("Stalled response changed.");

endmodule

bind nec_ir_frame_decoder_unit nifd_checker u_nifd_checker (.*);

`default_nettype wire
